### hdl/utf8e_pkg.sv
// Shared types and constants for the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
package utf8e_pkg;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  localparam logic [15:0] SURR_HIGH_BASE = 16'hd800;
  localparam logic [15:0] SURR_LOW_BASE  = 16'hdc00;
  localparam logic [15:0] SURR_END       = 16'he000;
  localparam logic [15:0] ONE_BYTE_LIM   = 16'h0080;
  localparam logic [15:0] TWO_BYTE_LIM   = 16'h0800;
  localparam logic [10:0] PLANE_OFFSET   = 11'd64;   // 0x10000 >> 10

  // One encoded character: up to four bytes, byte 0 leaves first.
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nbytes_m1;
    logic            bad;
  } job_t;

endpackage

### hdl/utf8e_front.sv
// Front end: classifies code units, pairs surrogates, builds byte jobs.
`timescale 1ns / 1ps
module utf8e_front import utf8e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        accept,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output logic        job_push,
  output job_t        job
);

  logic [9:0]  held_high_bits, held_high_bits_next;
  logic        high_pending, high_pending_next;
  logic        is_high, is_low, err;
  logic [10:0] plane;
  logic [20:0] cp;

  always_comb begin
    is_high = (code_unit >= SURR_HIGH_BASE) && (code_unit < SURR_LOW_BASE);
    is_low  = (code_unit >= SURR_LOW_BASE) && (code_unit < SURR_END);
    plane   = {1'b0, held_high_bits} + PLANE_OFFSET;
    cp      = {plane[10:0], code_unit[9:0]};
    err     = (high_pending != is_low) || (!high_pending && is_high && end_of_string);

    job                 = '0;
    job_push            = accept;
    high_pending_next   = high_pending;
    held_high_bits_next = held_high_bits;

    priority if (err) begin
      job.bad = 1'b1;
      if (accept) begin
        high_pending_next   = 1'b0;
        held_high_bits_next = '0;
      end
    end else if (high_pending) begin
      job.bytes[0]  = {5'b11110, cp[20:18]};
      job.bytes[1]  = {2'b10, cp[17:12]};
      job.bytes[2]  = {2'b10, cp[11:6]};
      job.bytes[3]  = {2'b10, cp[5:0]};
      job.nbytes_m1 = 2'd3;
      if (accept) begin
        high_pending_next   = 1'b0;
        held_high_bits_next = '0;
      end
    end else if (is_high) begin
      // held until the low half arrives; nothing to send yet
      job_push = 1'b0;
      if (accept) begin
        high_pending_next   = 1'b1;
        held_high_bits_next = code_unit[9:0];
      end
    end else if (code_unit < ONE_BYTE_LIM) begin
      job.bytes[0] = code_unit[7:0];
    end else if (code_unit < TWO_BYTE_LIM) begin
      job.bytes[0]  = {3'b110, code_unit[10:6]};
      job.bytes[1]  = {2'b10, code_unit[5:0]};
      job.nbytes_m1 = 2'd1;
    end else begin
      job.bytes[0]  = {4'b1110, code_unit[15:12]};
      job.bytes[1]  = {2'b10, code_unit[11:6]};
      job.bytes[2]  = {2'b10, code_unit[5:0]};
      job.nbytes_m1 = 2'd2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      high_pending   <= 1'b0;
      held_high_bits <= '0;
    end else begin
      high_pending   <= high_pending_next;
      held_high_bits <= held_high_bits_next;
    end
  end

endmodule

### hdl/utf8e_queue.sv
// Short job queue between the front end and the byte serializer.
`timescale 1ns / 1ps
module utf8e_queue import utf8e_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr,
  input  job_t wr_job,
  output logic full,
  input  logic rd,
  output logic head_valid,
  output job_t head
);

  job_t              entries [QDEPTH];
  logic [QPTR_W-1:0] wptr, rptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QDEPTH));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (wr && !full) begin
      entries[wptr] <= wr_job;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr && !full) begin
        wptr <= wptr + 1'b1;
      end
      if (rd && head_valid) begin
        rptr <= rptr + 1'b1;
      end
      unique case ({wr && !full, rd && head_valid})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

### hdl/utf8e_back.sv
// Back end: sends one byte of the current job per request.
`timescale 1ns / 1ps
module utf8e_back import utf8e_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       head_valid,
  input  job_t       head,
  output logic       take,
  output logic       empty,
  input  logic       pop,
  output logic [7:0] out_byte,
  output logic       last_byte,
  output logic       bad_sequence
);

  job_t       cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       done;

  assign empty        = !cur_valid;
  assign out_byte     = cur.bytes[idx];
  assign last_byte    = (idx == cur.nbytes_m1);
  assign bad_sequence = cur.bad;
  assign done         = cur_valid && pop && last_byte;
  assign take         = head_valid && (!cur_valid || done);

  always_ff @(posedge clk) begin
    if (take) begin
      cur <= head;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= '0;
    end else begin
      priority if (take) begin
        cur_valid <= 1'b1;
        idx       <= '0;
      end else if (done) begin
        cur_valid <= 1'b0;
        idx       <= '0;
      end else if (cur_valid && pop) begin
        idx <= idx + 1'b1;
      end
    end
  end

endmodule

### hdl/utf16_to_utf8_encoder.sv
// Top level of the UTF-16 to UTF-8 encoder.
`timescale 1ns / 1ps
// Takes one UTF-16 code unit per push and delivers its UTF-8 bytes one per pop,
// last_byte marking the final byte of each unit; a high surrogate gives nothing
// until its low half arrives, then four bytes. Surrogate misuse gives a single
// result with bad_sequence set and out_byte zero. A unit is accepted whenever
// the four-entry job queue has room; the byte serializer sends one byte per
// cycle while pop is held, so the sustained rate is set by the byte count: one
// to four bytes per unit, four for supplementary characters.
module utf16_to_utf8_encoder import utf8e_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        push,
  output logic        full,
  input  logic [15:0] code_unit,
  input  logic        end_of_string,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_byte,
  output logic        last_byte,
  output logic        bad_sequence
);

  logic accept;
  logic job_push;
  job_t job;
  logic take;
  logic head_valid;
  job_t head;

  assign accept = push && !full;

  utf8e_front u_front (
    .clk           (clk),
    .rst           (rst),
    .accept        (accept),
    .code_unit     (code_unit),
    .end_of_string (end_of_string),
    .job_push      (job_push),
    .job           (job)
  );

  utf8e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .wr         (accept && job_push),
    .wr_job     (job),
    .full       (full),
    .rd         (take),
    .head_valid (head_valid),
    .head       (head)
  );

  utf8e_back u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .take         (take),
    .empty        (empty),
    .pop          (pop),
    .out_byte     (out_byte),
    .last_byte    (last_byte),
    .bad_sequence (bad_sequence)
  );

endmodule
